/* rtl/core/rtc3w_pkg.sv */
package rtc3w_pkg;

	// number of bytes returned by a burst read
	localparam int unsigned BURST_BYTES = 7;

	// command sent for a burst read, whatever command_byte holds
	localparam logic [7:0] BURST_CMD = 8'hBF;

	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_WRITE  = 2'd1,
		OP_SINGLE = 2'd2,
		OP_BURST  = 2'd3
	} op_t;

	// high nibble times ten plus low nibble, non-bcd nibbles included
	function automatic logic [7:0] bcd_to_dec(input logic [7:0] v);
		logic [7:0] hi;
		logic [7:0] lo;
		begin
			hi = {4'd0, v[7:4]};
			lo = {4'd0, v[3:0]};
			bcd_to_dec = (hi << 3) + (hi << 1) + lo;
		end
	endfunction

endpackage

/* rtl/core/three_wire_rtc_serial_master.sv */
// three-wire real-time-clock serial master
//
// input channel (in_valid/in_ready): each beat is one half-bit tick of the
// serial line. operation starts a write, a single read or a burst read when
// the block is idle; otherwise the tick just advances the transaction.
// command_byte/write_byte are taken on the start tick, io_sample is the
// sampled data line level on that tick.
// output channel (out_valid/out_ready): exactly one beat per input beat,
// carrying the pin levels (chip_enable, serial_clock, data_out, data_drive)
// and read results (read_valid, read_value, last_read) plus busy_res.
// the result of a tick is registered and appears in the cycle after it is accepted.
// throughput: one tick per cycle unless the receiver stalls; the sequencer
// state and the result register both update on the accepting edge, so the
// next tick enters while the previous result is being taken.
// when the receiver stalls, the result register holds and in_ready drops
// until it drains; the sequencer only moves on accepted ticks, so no
// serial-line timing is lost or invented.
// reset (arst_n low): sequencer idle, counters and shift register cleared,
// no result pending.
module three_wire_rtc_serial_master (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] operation,
	input  logic [7:0] command_byte,
	input  logic [7:0] write_byte,
	input  logic       io_sample,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       chip_enable,
	output logic       serial_clock,
	output logic       data_out,
	output logic       data_drive,
	output logic       read_valid,
	output logic [7:0] read_value,
	output logic       last_read,
	output logic       busy_res
);

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_CMD   = 3'd1,
		PH_WDATA = 3'd2,
		PH_RDATA = 3'd3,
		PH_END   = 3'd4
	} phase_t;

	// sequencer state
	phase_t          phase_q, phase_d;
	rtc3w_pkg::op_t  kind_q, kind_d;
	logic [2:0]      bit_count_q, bit_count_d;
	logic [2:0]      byte_count_q, byte_count_d;
	logic [7:0]      shift_q, shift_d;
	logic [7:0]      held_q, held_d;
	logic            half_q, half_d;

	// result register
	logic            out_valid_q;
	logic            ce_q, sclk_q, dout_q, drive_q, rvalid_q, rlast_q, busy_q;
	logic [7:0]      rvalue_q;

	// combinational result of the current tick
	logic            ce_c, sclk_c, dout_c, drive_c, rvalid_c, rlast_c, busy_c;
	logic [7:0]      rvalue_c;
	logic [7:0]      sampled;
	logic            last_byte;
	logic            in_fire;

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	assign sampled = {io_sample, shift_q[7:1]};
	// final byte of a read: single reads always, bursts on the last count
	assign last_byte = (kind_q != rtc3w_pkg::OP_BURST) ||
		(({1'b0, byte_count_q} + 4'd1) >= 4'(rtc3w_pkg::BURST_BYTES));

	always_comb begin
		phase_d      = phase_q;
		kind_d       = kind_q;
		bit_count_d  = bit_count_q;
		byte_count_d = byte_count_q;
		shift_d      = shift_q;
		held_d       = held_q;
		half_d       = half_q;
		ce_c         = 1'b0;
		sclk_c       = 1'b0;
		dout_c       = 1'b0;
		drive_c      = 1'b0;
		rvalid_c     = 1'b0;
		rvalue_c     = 8'd0;
		rlast_c      = 1'b0;
		busy_c       = 1'b0;
		case (phase_q)
			PH_CMD, PH_WDATA: begin
				busy_c  = 1'b1;
				ce_c    = 1'b1;
				drive_c = 1'b1;
				dout_c  = shift_q[0];
				if (!half_q) begin
					half_d = 1'b1;
				end else begin
					sclk_c  = 1'b1;
					half_d  = 1'b0;
					shift_d = shift_q >> 1;
					if (bit_count_q == 3'd7) begin
						bit_count_d = 3'd0;
						if (phase_q == PH_CMD && kind_q == rtc3w_pkg::OP_WRITE) begin
							phase_d = PH_WDATA;
							shift_d = held_q;
						end else if (phase_q == PH_CMD) begin
							phase_d      = PH_RDATA;
							shift_d      = 8'd0;
							byte_count_d = 3'd0;
						end else begin
							phase_d = PH_END;
						end
					end else begin
						bit_count_d = bit_count_q + 3'd1;
					end
				end
			end
			PH_RDATA: begin
				busy_c = 1'b1;
				ce_c   = 1'b1;
				if (!half_q) begin
					// clock low: sample into the top of a right shift
					shift_d = sampled;
					if (bit_count_q == 3'd7) begin
						rvalid_c = 1'b1;
						rvalue_c = rtc3w_pkg::bcd_to_dec(sampled);
						rlast_c  = last_byte;
					end
					half_d = 1'b1;
				end else begin
					sclk_c = 1'b1;
					half_d = 1'b0;
					if (bit_count_q == 3'd7) begin
						bit_count_d = 3'd0;
						if (last_byte) begin
							phase_d = PH_END;
						end else begin
							byte_count_d = byte_count_q + 3'd1;
							shift_d      = 8'd0;
						end
					end else begin
						bit_count_d = bit_count_q + 3'd1;
					end
				end
			end
			PH_END: begin
				// closing tick, starts here are dropped
				busy_c      = 1'b1;
				phase_d     = PH_IDLE;
				half_d      = 1'b0;
				bit_count_d = 3'd0;
			end
			default: begin
				phase_d = PH_IDLE;
				if (operation != rtc3w_pkg::OP_TICK) begin
					busy_c       = 1'b1;
					kind_d       = rtc3w_pkg::op_t'(operation);
					shift_d      = (operation == rtc3w_pkg::OP_BURST) ?
						rtc3w_pkg::BURST_CMD : command_byte;
					held_d       = write_byte;
					bit_count_d  = 3'd0;
					byte_count_d = 3'd0;
					half_d       = 1'b0;
					phase_d      = PH_CMD;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			kind_q       <= rtc3w_pkg::OP_TICK;
			bit_count_q  <= 3'd0;
			byte_count_q <= 3'd0;
			shift_q      <= 8'd0;
			held_q       <= 8'd0;
			half_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			ce_q         <= 1'b0;
			sclk_q       <= 1'b0;
			dout_q       <= 1'b0;
			drive_q      <= 1'b0;
			rvalid_q     <= 1'b0;
			rvalue_q     <= 8'd0;
			rlast_q      <= 1'b0;
			busy_q       <= 1'b0;
		end else begin
			if (in_fire) begin
				phase_q      <= phase_d;
				kind_q       <= kind_d;
				bit_count_q  <= bit_count_d;
				byte_count_q <= byte_count_d;
				shift_q      <= shift_d;
				held_q       <= held_d;
				half_q       <= half_d;
				out_valid_q  <= 1'b1;
				ce_q         <= ce_c;
				sclk_q       <= sclk_c;
				dout_q       <= dout_c;
				drive_q      <= drive_c;
				rvalid_q     <= rvalid_c;
				rvalue_q     <= rvalue_c;
				rlast_q      <= rlast_c;
				busy_q       <= busy_c;
			end else if (out_ready) begin
				out_valid_q  <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign chip_enable  = ce_q;
	assign serial_clock = sclk_q;
	assign data_out     = dout_q;
	assign data_drive   = drive_q;
	assign read_valid   = rvalid_q;
	assign read_value   = rvalue_q;
	assign last_read    = rlast_q;
	assign busy_res     = busy_q;

	// the closing tick always returns to idle
	a_end_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && phase_q == PH_END |=> phase_q == PH_IDLE)
		else $error("closing tick did not return to idle");

	// a received byte only shows with enable high and line released
	a_read_framed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && rvalid_q |-> ce_q && busy_q && !drive_q && !sclk_q)
		else $error("read byte outside a read clock-low tick");

	// last marker only with a received byte
	a_last_with_read: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && rlast_q |-> rvalid_q)
		else $error("last_read without read_valid");

	// clock pulses only inside an enabled frame
	a_clock_framed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && sclk_q |-> ce_q && busy_q)
		else $error("serial clock high outside a frame");

	// a stalled result holds while no tick is accepted
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(rvalue_q) && $stable(busy_q))
		else $error("result changed under stall");

endmodule

/* test/testbench.sv */
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// sender stops at this many ticks (a transfer in flight is finished)
	localparam int unsigned TICK_TARGET = 1050;
	// no idling on either side for the last stretch of ticks
	localparam int unsigned QUIET_TAIL = 150;
	// ticks after the start tick: command bits, data bits, closing tick
	localparam int unsigned SHORT_SPAN = 16 + 16 + 1;
	localparam int unsigned BURST_SPAN = 16 + 16 * rtc3w_pkg::BURST_BYTES + 1;
	localparam int unsigned CYCLE_LIMIT = 200000;

	// sequencer phases as the predictor tracks them
	typedef enum logic [2:0] {
		SEQ_IDLE,
		SEQ_CMD,
		SEQ_WDATA,
		SEQ_RDATA,
		SEQ_END
	} seq_t;

	// pin levels and read results of one tick
	typedef struct packed {
		logic       ce;
		logic       sclk;
		logic       dout;
		logic       drive;
		logic       rvalid;
		logic [7:0] rvalue;
		logic       rlast;
		logic       busy;
	} line_t;

	// serial line predictor plus the queue of line levels it expects
	class rtc_line_scoreboard;
		line_t          line_q[$];
		int unsigned    mismatches;
		seq_t           seq;
		rtc3w_pkg::op_t kind;
		logic [2:0]     bit_cnt;
		logic [2:0]     byte_cnt;
		logic [7:0]     shreg;
		logic [7:0]     held;
		logic           half;

		function new();
			mismatches = 0;
			seq = SEQ_IDLE;
			kind = rtc3w_pkg::OP_TICK;
			bit_cnt = '0;
			byte_cnt = '0;
			shreg = '0;
			held = '0;
			half = 1'b0;
		endfunction

		function int unsigned pending();
			return line_q.size();
		endfunction

		// advance the sequencer by one accepted tick and queue its line levels
		function void note_tick(rtc3w_pkg::op_t op, logic [7:0] cmd, logic [7:0] wb,
				logic io);
			line_t e;
			logic  last;
			e = '0;
			case (seq)
				SEQ_CMD, SEQ_WDATA: begin
					e.busy = 1'b1;
					e.ce = 1'b1;
					e.drive = 1'b1;
					e.dout = shreg[0];
					if (!half) begin
						half = 1'b1;
					end else begin
						e.sclk = 1'b1;
						half = 1'b0;
						shreg = shreg >> 1;
						if (bit_cnt == 3'd7) begin
							bit_cnt = '0;
							if (seq == SEQ_CMD && kind == rtc3w_pkg::OP_WRITE) begin
								seq = SEQ_WDATA;
								shreg = held;
							end else if (seq == SEQ_CMD) begin
								seq = SEQ_RDATA;
								shreg = '0;
								byte_cnt = '0;
							end else begin
								seq = SEQ_END;
							end
						end else begin
							bit_cnt = bit_cnt + 3'd1;
						end
					end
				end
				SEQ_RDATA: begin
					last = (kind != rtc3w_pkg::OP_BURST) ||
						(int'(byte_cnt) + 1 >= rtc3w_pkg::BURST_BYTES);
					e.busy = 1'b1;
					e.ce = 1'b1;
					if (!half) begin
						shreg = {io, shreg[7:1]};
						if (bit_cnt == 3'd7) begin
							e.rvalid = 1'b1;
							e.rvalue = 8'(int'(shreg[7:4]) * 10 + int'(shreg[3:0]));
							e.rlast = last;
						end
						half = 1'b1;
					end else begin
						e.sclk = 1'b1;
						half = 1'b0;
						if (bit_cnt == 3'd7) begin
							bit_cnt = '0;
							if (last) begin
								seq = SEQ_END;
							end else begin
								byte_cnt = byte_cnt + 3'd1;
								shreg = '0;
							end
						end else begin
							bit_cnt = bit_cnt + 3'd1;
						end
					end
				end
				SEQ_END: begin
					e.busy = 1'b1;
					seq = SEQ_IDLE;
					half = 1'b0;
					bit_cnt = '0;
				end
				default: begin
					seq = SEQ_IDLE;
					if (op != rtc3w_pkg::OP_TICK) begin
						e.busy = 1'b1;
						kind = op;
						shreg = (op == rtc3w_pkg::OP_BURST) ? rtc3w_pkg::BURST_CMD : cmd;
						held = wb;
						bit_cnt = '0;
						byte_cnt = '0;
						half = 1'b0;
						seq = SEQ_CMD;
					end
				end
			endcase
			line_q.push_back(e);
		endfunction

		task report(string what, int unsigned want, int unsigned got);
			$display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
			mismatches++;
		endtask

		task check_result(line_t got);
			line_t e;
			if (line_q.size() == 0) begin
				report("result beat with nothing pending", 0, 1);
			end else begin
				e = line_q.pop_front();
				if (got.ce !== e.ce) report("chip_enable", e.ce, got.ce);
				if (got.sclk !== e.sclk) report("serial_clock", e.sclk, got.sclk);
				if (got.dout !== e.dout) report("data_out", e.dout, got.dout);
				if (got.drive !== e.drive) report("data_drive", e.drive, got.drive);
				if (got.rvalid !== e.rvalid) report("read_valid", e.rvalid, got.rvalid);
				if (got.rvalue !== e.rvalue) report("read_value", e.rvalue, got.rvalue);
				if (got.rlast !== e.rlast) report("last_read", e.rlast, got.rlast);
				if (got.busy !== e.busy) report("busy_res", e.busy, got.busy);
			end
		endtask
	endclass

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [1:0] operation;
	logic [7:0] command_byte;
	logic [7:0] write_byte;
	logic       io_sample;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       chip_enable;
	logic       serial_clock;
	logic       data_out;
	logic       data_drive;
	logic       read_valid;
	logic [7:0] read_value;
	logic       last_read;
	logic       busy_res;

	rtc_line_scoreboard sb = new();

	int unsigned ticks_sent;
	int unsigned stall_left = 0;
	int unsigned cycle_count;
	bit          quiet;

	three_wire_rtc_serial_master dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.command_byte (command_byte),
		.write_byte   (write_byte),
		.io_sample    (io_sample),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.chip_enable  (chip_enable),
		.serial_clock (serial_clock),
		.data_out     (data_out),
		.data_drive   (data_drive),
		.read_valid   (read_valid),
		.read_value   (read_value),
		.last_read    (last_read),
		.busy_res     (busy_res)
	);

	// 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// watch both channels; values seen here are the ones from before the edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_tick(rtc3w_pkg::op_t'(operation), command_byte, write_byte,
					io_sample);
			if (out_valid && out_ready)
				sb.check_result({chip_enable, serial_clock, data_out, data_drive,
					read_valid, read_value, last_read, busy_res});
		end
	end

	// receiver: stalls of random length, none started in the quiet tail
	always @(posedge clk) begin
		if (stall_left != 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!quiet && $urandom_range(0, 11) == 0) begin
			out_ready <= 1'b0;
			stall_left <= $urandom_range(0, 7);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// hard stop in case the block hangs
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("testbench NOT OK");
		$finish;
	end

	// one tick beat; valid stays high after acceptance unless a gap follows
	task send_tick(rtc3w_pkg::op_t op, logic [7:0] cmd, logic [7:0] wb, logic io);
		if (!quiet && $urandom_range(0, 15) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		command_byte <= cmd;
		write_byte <= wb;
		io_sample <= io;
		do @(posedge clk); while (!in_ready);
		ticks_sent++;
		if (ticks_sent + QUIET_TAIL >= TICK_TARGET)
			quiet = 1'b1;
	endtask

	// hold off the sender until every result beat is back
	task drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// one whole transaction from the start tick through the closing tick
	// io follows fill on clock-low ticks so each read byte equals fill (a random byte per read byte with random_fill);
	// noisy puts ignored starts on busy ticks and always on the closing tick
	task run_transfer(rtc3w_pkg::op_t op, logic [7:0] cmd, logic [7:0] wb,
			logic [7:0] fill, bit noisy, bit random_fill);
		int unsigned    span;
		logic [7:0]     rd_byte;
		rtc3w_pkg::op_t busy_op;
		span = (op == rtc3w_pkg::OP_BURST) ? BURST_SPAN : SHORT_SPAN;
		rd_byte = fill;
		send_tick(op, cmd, wb, 1'($urandom));
		for (int unsigned t = 0; t < span; t++) begin
			// a new read byte starts every 16 ticks
			if (random_fill && t % 16 == 0)
				rd_byte = ($urandom_range(0, 2) == 0) ? 8'($urandom)
					: {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
			if (noisy && (t == span - 1 || $urandom_range(0, 3) == 0))
				busy_op = rtc3w_pkg::op_t'($urandom_range(1, 3));
			else
				busy_op = rtc3w_pkg::OP_TICK;
			send_tick(busy_op, 8'($urandom), 8'($urandom),
				(t % 2 == 0) ? rd_byte[(t / 2) % 8] : 1'($urandom));
		end
	endtask

	initial begin
		rtc3w_pkg::op_t pick;
		int unsigned    roll;
		bit             mid_drain_done;
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = rtc3w_pkg::OP_TICK;
		command_byte = '0;
		write_byte = '0;
		io_sample = 1'b0;
		ticks_sent = 0;
		quiet = 1'b0;
		mid_drain_done = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle ticks with op 0 must leave every output low
		send_tick(rtc3w_pkg::OP_TICK, 8'hFF, 8'hFF, 1'b1);
		send_tick(rtc3w_pkg::OP_TICK, 8'h00, 8'h00, 1'b0);
		// writes with extreme command and data bytes
		run_transfer(rtc3w_pkg::OP_WRITE, 8'hFF, 8'h00, 8'h00, 1'b0, 1'b0);
		run_transfer(rtc3w_pkg::OP_WRITE, 8'h00, 8'hFF, 8'hFF, 1'b1, 1'b0);
		// single reads: a clean bcd byte and the non-bcd maximum
		run_transfer(rtc3w_pkg::OP_SINGLE, 8'h81, 8'hA5, 8'h59, 1'b0, 1'b0);
		run_transfer(rtc3w_pkg::OP_SINGLE, 8'h01, 8'h5A, 8'hFF, 1'b1, 1'b0);
		// bursts: command_byte ignored, fixed burst command goes out
		run_transfer(rtc3w_pkg::OP_BURST, 8'h00, 8'hFF, 8'h00, 1'b1, 1'b0);
		run_transfer(rtc3w_pkg::OP_BURST, 8'hFF, 8'h00, 8'h99, 1'b0, 1'b1);

		// sender pauses until the line is fully drained
		drain_results();

		// random transactions with a few idle ticks in between
		while (ticks_sent < TICK_TARGET) begin
			repeat ($urandom_range(0, 3))
				send_tick(rtc3w_pkg::OP_TICK, 8'($urandom), 8'($urandom), 1'($urandom));
			roll = $urandom_range(0, 99);
			if (roll < 40)
				pick = rtc3w_pkg::OP_WRITE;
			else if (roll < 75)
				pick = rtc3w_pkg::OP_SINGLE;
			else
				pick = rtc3w_pkg::OP_BURST;
			run_transfer(pick, 8'($urandom), 8'($urandom), 8'($urandom),
				1'($urandom), 1'b1);
			if (!mid_drain_done && ticks_sent > TICK_TARGET / 2) begin
				drain_results();
				mid_drain_done = 1'b1;
			end
		end

		// let the last result beats come back, then idle before the final check
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (sb.pending() != 0)
			sb.report("result beats still pending", 0, sb.pending());
		if (sb.mismatches == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule
